// ----- sv/chbd_pkg.sv -----
// Shared types, field widths and command and status codes for the canonical Huffman decoder.
package chbd_pkg;

  localparam int SYMBOL_BITS        = 9;
  localparam int VALUE_BITS         = 9;
  localparam int MAX_CODE_LEN_DEF   = 32;
  localparam int ALPHABET_DEPTH_DEF = 512;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_SYMBOL = 2'd1;
  localparam logic [1:0] CMD_COUNT  = 2'd2;
  localparam logic [1:0] CMD_BIT    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_HEADER  = 2'd2;

  typedef struct packed {
    logic [1:0]            command;
    logic [VALUE_BITS-1:0] value;
    logic                  bit_req;
  } req_item_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] symbol;
    logic [1:0]             status;
  } rsp_item_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
  } walk_res_t;

endpackage

// ----- sv/canonical_huffman_bit_decoder_top.sv -----
// A result appears in the cycle after the transaction that causes it is accepted.
// Throughput: one transaction per cycle, set by the single registered decode step and the
// one read port of the symbol memory; the input stalls only while a result waits stalled.
// Reset clears the header table, the code walk registers and the result valid flag.
// The symbol memory is not cleared; entries are read only after being loaded.
module canonical_huffman_bit_decoder_top #(
  parameter int MAX_CODE_LEN   = chbd_pkg::MAX_CODE_LEN_DEF,
  parameter int ALPHABET_DEPTH = chbd_pkg::ALPHABET_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  chbd_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output chbd_pkg::rsp_item_t rsp
);
  import chbd_pkg::*;

  localparam int LI_W   = $clog2(MAX_CODE_LEN);
  localparam int ADDR_W = $clog2(ALPHABET_DEPTH);

  logic                   accept;
  logic [LI_W-1:0]        code_length;
  logic [VALUE_BITS-1:0]  count;
  logic                   hdr_err;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [SYMBOL_BITS-1:0] wr_data;
  walk_res_t              wres;
  logic [ADDR_W-1:0]      idx;
  logic [SYMBOL_BITS-1:0] rd_data;
  logic                   has_result;
  logic [1:0]             rsp_status;
  logic [1:0]             rsp_status_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  chbd_table #(
    .MAX_CODE_LEN   (MAX_CODE_LEN),
    .ALPHABET_DEPTH (ALPHABET_DEPTH)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .item        (req),
    .code_length (code_length),
    .count       (count),
    .hdr_err     (hdr_err),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  chbd_walk #(
    .MAX_CODE_LEN   (MAX_CODE_LEN),
    .ALPHABET_DEPTH (ALPHABET_DEPTH)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .item        (req),
    .count       (count),
    .code_length (code_length),
    .res         (wres),
    .idx         (idx)
  );

  chbd_store #(
    .ALPHABET_DEPTH (ALPHABET_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept && wres.hit),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  assign has_result = ((req.command == CMD_COUNT) && hdr_err) || wres.hit || wres.exhausted;

  always_comb begin
    if (wres.hit) begin
      rsp_status_next = ST_OK;
    end else if (wres.exhausted) begin
      rsp_status_next = ST_INVALID;
    end else begin
      rsp_status_next = ST_HEADER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept && has_result) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      rsp_status <= rsp_status_next;
    end
  end

  assign rsp.symbol = (rsp_status == ST_OK) ? rd_data : '0;
  assign rsp.status = rsp_status;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept && has_result |=> rsp_valid)
    else $error("Accepted transaction with a result did not raise rsp_valid.");

  a_hit_reports_ok: assert property (@(posedge clk) disable iff (rst)
    accept && wres.hit |=> rsp.status == ST_OK)
    else $error("Matched code did not report a decoded symbol.");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid && !(accept && has_result) |=> !rsp_valid)
    else $error("Result appeared without a transaction that causes one.");

endmodule

// ----- sv/chbd_table.sv -----
// Table header state: symbol count, per-length code counts, code space tracking and header checks.
module chbd_table #(
  parameter int MAX_CODE_LEN   = chbd_pkg::MAX_CODE_LEN_DEF,
  parameter int ALPHABET_DEPTH = chbd_pkg::ALPHABET_DEPTH_DEF,
  parameter int LI_W           = $clog2(MAX_CODE_LEN),
  parameter int ADDR_W         = $clog2(ALPHABET_DEPTH)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  chbd_pkg::req_item_t                    item,
  input  logic [LI_W-1:0]                        code_length,
  output logic [chbd_pkg::VALUE_BITS-1:0]        count,
  output logic                                   hdr_err,
  output logic                                   wr_en,
  output logic [ADDR_W-1:0]                      wr_addr,
  output logic [chbd_pkg::SYMBOL_BITS-1:0]       wr_data
);
  import chbd_pkg::*;

  localparam int CNT_W = $clog2(ALPHABET_DEPTH + 1);
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int SP_W  = MAX_CODE_LEN + 1;
  localparam int AV_W  = MAX_CODE_LEN + 2;

  logic [CNT_W-1:0]      symbols_loaded;
  logic [CNT_W-1:0]      counts_total;
  logic [LEN_W-1:0]      lengths_loaded;
  logic [SP_W-1:0]       space_next;
  logic [VALUE_BITS-1:0] length_counts [MAX_CODE_LEN];

  logic [CNT_W:0]   total_sum;
  logic [LEN_W-1:0] len_new;
  logic [AV_W-1:0]  avail_need;
  logic [AV_W-1:0]  space_limit;
  logic             table_full;
  logic             over_symbols;
  logic             over_space;
  logic             count_ok;

  assign total_sum    = {1'b0, counts_total} + (CNT_W + 1)'(item.value);
  assign len_new      = lengths_loaded + LEN_W'(1);
  assign avail_need   = {space_next, 1'b0} + AV_W'(item.value);
  assign space_limit  = AV_W'(1) << len_new;
  assign table_full   = lengths_loaded >= LEN_W'(MAX_CODE_LEN);
  assign over_symbols = total_sum > {1'b0, symbols_loaded};
  assign over_space   = avail_need > space_limit;
  assign hdr_err      = table_full || over_symbols || over_space;
  assign count_ok     = en && (item.command == CMD_COUNT) && !hdr_err;

  assign count   = length_counts[code_length];
  assign wr_en   = en && (item.command == CMD_SYMBOL)
                   && (symbols_loaded < CNT_W'(ALPHABET_DEPTH));
  assign wr_addr = symbols_loaded[ADDR_W-1:0];
  assign wr_data = item.value;

  always_ff @(posedge clk) begin
    if (rst || (en && item.command == CMD_CLEAR)) begin
      symbols_loaded <= '0;
      counts_total   <= '0;
      lengths_loaded <= '0;
      space_next     <= '0;
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        length_counts[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        symbols_loaded <= symbols_loaded + CNT_W'(1);
      end
      if (count_ok) begin
        length_counts[lengths_loaded[LI_W-1:0]] <= item.value;
        lengths_loaded <= len_new;
        counts_total   <= total_sum[CNT_W-1:0];
        space_next     <= avail_need[SP_W-1:0];
      end
    end
  end

endmodule

// ----- sv/chbd_walk.sv -----
// Per-bit code walk: code, first-code, index base and length registers with the canonical match test.
module chbd_walk #(
  parameter int MAX_CODE_LEN   = chbd_pkg::MAX_CODE_LEN_DEF,
  parameter int ALPHABET_DEPTH = chbd_pkg::ALPHABET_DEPTH_DEF,
  parameter int LI_W           = $clog2(MAX_CODE_LEN),
  parameter int ADDR_W         = $clog2(ALPHABET_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  chbd_pkg::req_item_t             item,
  input  logic [chbd_pkg::VALUE_BITS-1:0] count,
  output logic [LI_W-1:0]                 code_length,
  output chbd_pkg::walk_res_t             res,
  output logic [ADDR_W-1:0]               idx
);
  import chbd_pkg::*;

  localparam int CNT_W = $clog2(ALPHABET_DEPTH + 1);
  localparam int CMP_W = (MAX_CODE_LEN > VALUE_BITS) ? MAX_CODE_LEN : VALUE_BITS;

  logic [MAX_CODE_LEN-1:0] code_accum;
  logic [MAX_CODE_LEN-1:0] first_code;
  logic [CNT_W-1:0]        index_base;

  logic [MAX_CODE_LEN-1:0] code;
  logic [MAX_CODE_LEN-1:0] first;
  logic [MAX_CODE_LEN-1:0] diff;
  logic [CMP_W-1:0]        diff_ext;
  logic [CMP_W-1:0]        count_ext;
  logic [CMP_W-1:0]        first_sum;
  logic [CNT_W-1:0]        idx_full;
  logic                    is_bit;
  logic                    last_len;

  assign is_bit    = item.command == CMD_BIT;
  assign code      = {code_accum[MAX_CODE_LEN-2:0], item.bit_req};
  assign first     = {first_code[MAX_CODE_LEN-2:0], 1'b0};
  assign diff      = code - first;
  assign diff_ext  = CMP_W'(diff);
  assign count_ext = CMP_W'(count);
  assign first_sum = CMP_W'(first) + count_ext;
  assign last_len  = code_length == LI_W'(MAX_CODE_LEN - 1);

  assign res.hit       = is_bit && (code >= first) && (diff_ext < count_ext);
  assign res.exhausted = is_bit && !res.hit && last_len;

  assign idx_full = index_base + CNT_W'(diff_ext);
  assign idx      = idx_full[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || (en && (!is_bit || res.hit || res.exhausted))) begin
      code_accum  <= '0;
      first_code  <= '0;
      index_base  <= '0;
      code_length <= '0;
    end else if (en) begin
      code_accum  <= code;
      first_code  <= first_sum[MAX_CODE_LEN-1:0];
      index_base  <= index_base + CNT_W'(count);
      code_length <= code_length + LI_W'(1);
    end
  end

endmodule

// ----- sv/chbd_store.sv -----
// Symbol memory with one write port and one registered read port.
module chbd_store #(
  parameter int ALPHABET_DEPTH = chbd_pkg::ALPHABET_DEPTH_DEF,
  parameter int ADDR_W         = $clog2(ALPHABET_DEPTH)
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [ADDR_W-1:0]                wr_addr,
  input  logic [chbd_pkg::SYMBOL_BITS-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [ADDR_W-1:0]                rd_addr,
  output logic [chbd_pkg::SYMBOL_BITS-1:0] rd_data
);
  import chbd_pkg::*;

  logic [SYMBOL_BITS-1:0] mem [ALPHABET_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- bench/canonical_huffman_bit_decoder_top_tb.sv -----
// Self-checking testbench for the canonical Huffman bit decoder: header loads, code bits and errors.
module canonical_huffman_bit_decoder_top_tb;
  import chbd_pkg::*;

  localparam int LIMIT     = 300000;
  localparam int ITEM_GOAL = 1350;

  class decode_board;
    bit [SYMBOL_BITS-1:0] sym_mem [ALPHABET_DEPTH_DEF];
    int unsigned          len_cnt [MAX_CODE_LEN_DEF];
    int unsigned          n_syms;
    int unsigned          n_lens;
    int unsigned          cnt_sum;
    longint unsigned      free_code;
    bit [31:0]            code_bits;
    bit [31:0]            first_bits;
    bit [9:0]             base_idx;
    int unsigned          bits_in;
    rsp_item_t            due_results[$];
    int                   errors;

    function new();
      foreach (sym_mem[i]) sym_mem[i] = '0;
      errors = 0;
      clear_table();
    endfunction

    function void restart_code();
      code_bits  = '0;
      first_bits = '0;
      base_idx   = '0;
      bits_in    = 0;
    endfunction

    function void clear_table();
      n_syms = 0;
      foreach (len_cnt[i]) len_cnt[i] = 0;
      n_lens    = 0;
      cnt_sum   = 0;
      free_code = 0;
      restart_code();
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void queue_result(rsp_item_t r);
      due_results.insert(due_results.size(), r);
    endfunction

    function void note_request(req_item_t it);
      rsp_item_t       r;
      longint unsigned avail;
      bit [31:0]       c;
      bit [31:0]       f;
      int unsigned     l;
      int unsigned     cnt;
      int unsigned     idx;
      r = '0;
      case (it.command)
        CMD_CLEAR: begin
          clear_table();
        end
        CMD_SYMBOL: begin
          restart_code();
          if (n_syms < ALPHABET_DEPTH_DEF) begin
            sym_mem[n_syms] = it.value;
            n_syms++;
          end
        end
        CMD_COUNT: begin
          restart_code();
          avail = free_code << 1;
          if (n_lens >= MAX_CODE_LEN_DEF || cnt_sum + it.value > n_syms
              || avail + it.value > (64'd1 << (n_lens + 1))) begin
            r.status = ST_HEADER;
            queue_result(r);
          end else begin
            len_cnt[n_lens] = it.value;
            n_lens++;
            cnt_sum += it.value;
            free_code = avail + it.value;
          end
        end
        default: begin
          l   = bits_in + 1;
          c   = {code_bits[30:0], it.bit_req};
          f   = {first_bits[30:0], 1'b0};
          cnt = (l > MAX_CODE_LEN_DEF) ? 0 : len_cnt[l - 1];
          if (c >= f && c - f < cnt) begin
            idx = base_idx + (c - f);
            r.symbol = (idx < ALPHABET_DEPTH_DEF) ? sym_mem[idx] : '0;
            r.status = ST_OK;
            restart_code();
            queue_result(r);
          end else if (l >= MAX_CODE_LEN_DEF) begin
            r.status = ST_INVALID;
            restart_code();
            queue_result(r);
          end else begin
            code_bits  = c;
            first_bits = f + cnt;
            base_idx   = base_idx + 10'(cnt);
            bits_in    = l;
          end
        end
      endcase
    endfunction

    function void check_result(rsp_item_t got);
      rsp_item_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual symbol %0d status %0d",
                 $time, got.symbol, got.status);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.symbol !== want.symbol) begin
        $display("%0t: symbol mismatch, expected %0d, actual %0d",
                 $time, want.symbol, got.symbol);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_item_t   req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_item_t   rsp;

  decode_board board;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned burst_left = 0;
  int unsigned ep = 0;
  logic [15:0] stall_tick = '0;
  int unsigned tab_cnt [1:32];
  int unsigned tab_lens;
  int unsigned tab_total;

  canonical_huffman_bit_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[9:8])
      2'd0: rsp_stall <= 1'b0;
      2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
      default: rsp_stall <= (stall_tick % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (!rst && rsp_valid && !rsp_stall) begin
      board.check_result(rsp);
    end
  end

  task automatic send_item(input logic [1:0] cmd, input int unsigned val,
                           input int unsigned b);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    req.command = cmd;
    req.value   = val[8:0];
    req.bit_req = b[0];
    req_valid   = 1'b1;
    do @(posedge clk); while (req_stall);
    board.note_request(req);
    sent++;
  endtask

  task automatic send_bits(input longint unsigned code, input int unsigned n);
    for (int i = int'(n) - 1; i >= 0; i--) begin
      send_item(CMD_BIT, $urandom_range(0, 511), code[i]);
    end
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    req_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic start_table(input int unsigned nsym);
    send_item(CMD_CLEAR, $urandom_range(0, 511), $urandom_range(0, 1));
    repeat (nsym) send_item(CMD_SYMBOL, $urandom_range(0, 511), $urandom_range(0, 1));
    tab_lens  = 0;
    tab_total = 0;
  endtask

  task automatic add_count(input int unsigned c);
    send_item(CMD_COUNT, c, $urandom_range(0, 1));
    tab_lens++;
    tab_cnt[tab_lens] = c;
    tab_total += c;
  endtask

  task automatic emit_code(input int unsigned idx);
    longint unsigned first;
    int unsigned     base;
    first = 0;
    base  = 0;
    for (int l = 1; l <= int'(tab_lens); l++) begin
      if (idx < base + tab_cnt[l]) begin
        send_bits(first + idx - base, l);
        return;
      end
      base += tab_cnt[l];
      first = (first + tab_cnt[l]) << 1;
    end
  endtask

  task automatic random_table();
    int unsigned     nsym;
    int unsigned     nl;
    int unsigned     rem;
    int unsigned     c;
    longint unsigned sp;
    longint unsigned room;
    nsym = ($urandom_range(0, 5) == 0) ? $urandom_range(21, 80) : $urandom_range(1, 20);
    start_table(nsym);
    nl  = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 10);
    rem = nsym;
    sp  = 0;
    for (int l = 1; l <= int'(nl); l++) begin
      room = (64'd1 << l) - (sp << 1);
      c = (room < rem) ? int'(room) : rem;
      if (l < int'(nl) && $urandom_range(0, 2) != 0) c = $urandom_range(0, c);
      add_count(c);
      sp = (sp << 1) + c;
      rem -= c;
      if ($urandom_range(0, 9) == 0) send_bits($urandom, $urandom_range(1, 4));
    end
    if ($urandom_range(0, 2) == 0) begin
      send_item(CMD_COUNT, rem + 1 + $urandom_range(0, 510 - rem), $urandom_range(0, 1));
    end
    repeat ($urandom_range(4, 24)) begin
      if (tab_total > 0 && $urandom_range(0, 9) != 0) begin
        emit_code($urandom_range(0, tab_total - 1));
      end else begin
        send_bits({$urandom, $urandom}, $urandom_range(1, 8));
      end
    end
  endtask

  task automatic noise_burst();
    logic [1:0] cmd;
    repeat ($urandom_range(10, 40)) begin
      cmd = ($urandom_range(0, 19) == 0) ? CMD_CLEAR : 2'($urandom_range(CMD_SYMBOL, CMD_BIT));
      send_item(cmd, $urandom_range(0, 511), $urandom_range(0, 1));
    end
  endtask

  initial begin
    board = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed header and decode cases.
    send_item(CMD_CLEAR, 9'd0, 1'b0);
    send_item(CMD_SYMBOL, 9'h000, 1'b1);
    send_item(CMD_SYMBOL, 9'h1ff, 1'b0);
    send_item(CMD_SYMBOL, 9'h0aa, 1'b1);
    send_item(CMD_SYMBOL, 9'h155, 1'b0);
    send_item(CMD_COUNT, 9'd3, 1'b0);
    send_item(CMD_COUNT, 9'd5, 1'b1);
    send_item(CMD_COUNT, 9'd1, 1'b0);
    send_item(CMD_BIT, 9'h1ff, 1'b0);
    send_item(CMD_BIT, 9'h000, 1'b1);
    send_item(CMD_COUNT, 9'd1, 1'b1);
    send_item(CMD_BIT, 9'd0, 1'b1);
    send_item(CMD_BIT, 9'd0, 1'b0);
    send_item(CMD_BIT, 9'd0, 1'b1);
    send_item(CMD_SYMBOL, 9'h0f0, 1'b1);
    send_item(CMD_BIT, 9'd0, 1'b0);
    send_item(CMD_COUNT, 9'd2, 1'b0);
    send_item(CMD_BIT, 9'd0, 1'b1);
    send_item(CMD_BIT, 9'd0, 1'b1);
    send_item(CMD_BIT, 9'd0, 1'b1);
    send_item(CMD_COUNT, 9'd0, 1'b0);
    send_item(CMD_COUNT, 9'd1, 1'b0);
    send_item(CMD_CLEAR, 9'h1ff, 1'b1);
    send_item(CMD_BIT, 9'd0, 1'b0);

    while (sent < ITEM_GOAL) begin
      case (ep)
        0: begin
          start_table(3);
          add_count(1);
          send_bits(64'hffff_ffff, 32);
          emit_code(0);
          send_bits({$urandom, $urandom}, 40);
          pause_until_drained();
        end
        1: begin
          start_table(33);
          for (int l = 1; l <= 31; l++) add_count(1);
          add_count(2);
          send_item(CMD_COUNT, 9'd0, 1'b0);
          emit_code(31);
          emit_code(32);
          repeat (6) emit_code($urandom_range(0, 32));
        end
        2: begin
          start_table(513);
          for (int l = 1; l <= 8; l++) add_count(0);
          add_count(511);
          add_count(1);
          emit_code(0);
          emit_code(510);
          emit_code(511);
          repeat (8) emit_code($urandom_range(0, 511));
        end
        default: begin
          if ($urandom_range(0, 5) == 0) noise_burst();
          else random_table();
          if ($urandom_range(0, 7) == 0) pause_until_drained();
        end
      endcase
      ep++;
    end

    @(negedge clk);
    req_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
